// ===== hdl/mau_pkg.sv =====
// shared types and constants for the modular arithmetic unit
package mau_pkg;

  localparam int unsigned MOD_W = 30;

  // operation codes
  typedef enum logic [3:0] {
    FN_RED = 4'd0,
    FN_ADD = 4'd1,
    FN_SUB = 4'd2,
    FN_MUL = 4'd3,
    FN_DIV = 4'd4,
    FN_POW = 4'd5,
    FN_INV = 4'd6,
    FN_NEG = 4'd7,
    FN_EQU = 4'd8
  } func_t;

  localparam logic [MOD_W-1:0] MODULUS_RESET = 30'd998244353;

endpackage

// ===== hdl/modular_arithmetic_unit.sv =====
// top level of the modular arithmetic unit
//
//  channel  | ports                                        | handshake
//  request  | in_func, in_operand_a/b, in_exponent         | start & !busy
//  result   | out_result, out_is_equal                     | out_valid, one cycle
//  config   | cfg_we, cfg_modulus                          | cfg_we
//
// a request reduces each operand with a bit-serial remainder unit;
// a modular product uses the same unit on the 60-bit product.
// reduce/add/sub/neg/equal strobe the result after both operands are reduced; mul adds a product;
// pow and inv always run EXP_BITS rounds: a squaring each, a product per set bit;
// div adds one more product.
// reset is synchronous and active low; the result is not held off by the receiver.
module modular_arithmetic_unit #(
  parameter int EXP_BITS = 63
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [3:0]                    in_func,
  input  logic signed [63:0]            in_operand_a,
  input  logic signed [63:0]            in_operand_b,
  input  logic [62:0]                   in_exponent,
  input  logic                          cfg_we,
  input  logic [mau_pkg::MOD_W-1:0]     cfg_modulus,
  output logic                          out_valid,
  output logic [mau_pkg::MOD_W-1:0]     out_result,
  output logic                          out_is_equal
);

  localparam int MW = mau_pkg::MOD_W;
  localparam int CW = $clog2(EXP_BITS + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_REDA  = 9'b000000010,
    S_REDB  = 9'b000000100,
    S_DISP  = 9'b000001000,
    S_PSTEP = 9'b000010000,
    S_PMUL  = 9'b000100000,
    S_PSQR  = 9'b001000000,
    S_FMUL  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [MW-1:0]      mod_r;
  logic [3:0]         func_r;
  logic [63:0]        opa_r, opb_r;
  logic [EXP_BITS-1:0] exp_r, exp_nxt;
  logic               nega_r, negb_r;
  logic [MW-1:0]      a_r, a_nxt, b_r, b_nxt;
  logic [MW-1:0]      acc_r, acc_nxt, sq_r, sq_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [MW-1:0]      res_r, res_nxt;
  logic               eq_r, eq_nxt;
  logic               valid_r, valid_nxt;
  logic               wait_r, wait_nxt;
  logic               inv_zero_r, inv_zero_nxt;

  // shared remainder unit and its operand
  logic               rd_go;
  logic [63:0]        rd_val;
  logic               rd_done;
  logic [MW-1:0]      rd_rem;
  logic [MW-1:0]      mul_x, mul_y;
  logic [2*MW-1:0]    prod;
  logic [MW-1:0]      signed_rem;
  logic [MW:0]        sum;
  logic [MW:0]        dif;

  mau_modred u_red (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (rd_go),
    .value   (rd_val),
    .modulus (mod_r),
    .done    (rd_done),
    .rem     (rd_rem)
  );

  assign prod = mul_x * mul_y;

  // operand negative: fold the remainder of the magnitude back
  always_comb begin
    logic neg;
    neg = (state_r == S_REDA) ? nega_r : negb_r;
    if (neg && rd_rem != '0) begin
      signed_rem = mod_r - rd_rem;
    end else begin
      signed_rem = rd_rem;
    end
  end

  assign sum = {1'b0, a_r} + {1'b0, b_r};
  assign dif = {1'b0, a_r} + {1'b0, mod_r} - {1'b0, b_r};

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    acc_nxt      = acc_r;
    sq_nxt       = sq_r;
    exp_nxt      = exp_r;
    cnt_nxt      = cnt_r;
    res_nxt      = res_r;
    eq_nxt       = eq_r;
    valid_nxt    = 1'b0;
    wait_nxt     = 1'b0;
    inv_zero_nxt = inv_zero_r;
    rd_go        = 1'b0;
    rd_val       = 64'd0;
    mul_x        = acc_r;
    mul_y        = sq_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_REDA;
          wait_nxt  = 1'b1;
        end
      end
      S_REDA: begin
        rd_val = nega_r ? (~opa_r + 64'd1) : opa_r;
        rd_go  = wait_r;
        if (rd_done) begin
          a_nxt     = signed_rem;
          state_nxt = S_REDB;
          wait_nxt  = 1'b1;
        end
      end
      S_REDB: begin
        rd_val = negb_r ? (~opb_r + 64'd1) : opb_r;
        rd_go  = wait_r;
        if (rd_done) begin
          b_nxt     = signed_rem;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        res_nxt   = '0;
        eq_nxt    = 1'b0;
        state_nxt = S_DONE;
        cnt_nxt   = '0;
        acc_nxt   = (mod_r == MW'(1)) ? '0 : MW'(1);
        inv_zero_nxt = 1'b0;
        if (mod_r < MW'(2)) begin
          eq_nxt = (func_r == mau_pkg::FN_EQU);
        end else begin
          unique case (func_r)
            mau_pkg::FN_RED: res_nxt = a_r;
            mau_pkg::FN_ADD: res_nxt = (sum >= {1'b0, mod_r}) ?
                                       MW'(sum - {1'b0, mod_r}) : MW'(sum);
            mau_pkg::FN_SUB: res_nxt = (dif >= {1'b0, mod_r}) ?
                                       MW'(dif - {1'b0, mod_r}) : MW'(dif);
            mau_pkg::FN_NEG: res_nxt = (a_r != '0) ? mod_r - a_r : '0;
            mau_pkg::FN_EQU: eq_nxt = (a_r == b_r);
            mau_pkg::FN_MUL: begin
              acc_nxt   = a_r;
              sq_nxt    = b_r;
              state_nxt = S_FMUL;
              wait_nxt  = 1'b1;
            end
            mau_pkg::FN_POW: begin
              sq_nxt    = a_r;
              state_nxt = S_PSTEP;
            end
            mau_pkg::FN_INV, mau_pkg::FN_DIV: begin
              sq_nxt  = (func_r == mau_pkg::FN_DIV) ? b_r : a_r;
              exp_nxt = EXP_BITS'(mod_r - MW'(2));
              inv_zero_nxt = (sq_nxt == '0);
              state_nxt = S_PSTEP;
            end
            default: ;
          endcase
        end
      end
      S_PSTEP: begin
        if (cnt_r == CW'(EXP_BITS)) begin
          if (func_r == mau_pkg::FN_DIV) begin
            sq_nxt    = inv_zero_r ? '0 : acc_r;
            acc_nxt   = a_r;
            state_nxt = S_FMUL;
            wait_nxt  = 1'b1;
          end else begin
            res_nxt   = inv_zero_r ? '0 : acc_r;
            state_nxt = S_DONE;
          end
        end else if (exp_r[0]) begin
          state_nxt = S_PMUL;
          wait_nxt  = 1'b1;
        end else begin
          state_nxt = S_PSQR;
          wait_nxt  = 1'b1;
        end
      end
      S_PMUL: begin
        rd_val = {{(64-2*MW){1'b0}}, prod};
        rd_go  = wait_r;
        if (rd_done) begin
          acc_nxt   = rd_rem;
          state_nxt = S_PSQR;
          wait_nxt  = 1'b1;
        end
      end
      S_PSQR: begin
        mul_x  = sq_r;
        rd_val = {{(64-2*MW){1'b0}}, prod};
        rd_go  = wait_r;
        if (rd_done) begin
          sq_nxt    = rd_rem;
          exp_nxt   = exp_r >> 1;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_PSTEP;
        end
      end
      S_FMUL: begin
        rd_val = {{(64-2*MW){1'b0}}, prod};
        rd_go  = wait_r;
        if (rd_done) begin
          res_nxt   = rd_rem;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and data registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
      wait_r  <= 1'b0;
      mod_r   <= mau_pkg::MODULUS_RESET;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      wait_r  <= wait_nxt;
      if (cfg_we) begin
        mod_r <= cfg_modulus;
      end
    end
    if (state_r == S_IDLE && start) begin
      func_r <= in_func;
      opa_r  <= in_operand_a;
      opb_r  <= in_operand_b;
      nega_r <= in_operand_a[63];
      negb_r <= in_operand_b[63];
      exp_r  <= in_exponent[EXP_BITS-1:0];
    end else begin
      exp_r <= exp_nxt;
    end
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    acc_r      <= acc_nxt;
    sq_r       <= sq_nxt;
    cnt_r      <= cnt_nxt;
    res_r      <= res_nxt;
    eq_r       <= eq_nxt;
    inv_zero_r <= inv_zero_nxt;
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = valid_r;
  assign out_result   = res_r;
  assign out_is_equal = eq_r;

endmodule

// ===== hdl/mau_modred.sv =====
// iterative remainder unit: 64-bit magnitude modulo a 30-bit modulus, one bit a cycle
module mau_modred (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [63:0]                   value,
  input  logic [mau_pkg::MOD_W-1:0]     modulus,
  output logic                          done,
  output logic [mau_pkg::MOD_W-1:0]     rem
);

  logic [63:0]               val_r, val_nxt;
  logic [mau_pkg::MOD_W:0]   rem_r, rem_nxt;
  logic [6:0]                cnt_r, cnt_nxt;
  logic                      run_r, run_nxt;
  logic                      done_r, done_nxt;
  logic [mau_pkg::MOD_W+1:0] shifted;

  // restoring shift-subtract step
  always_comb begin
    val_nxt  = val_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, val_r[63]};
    if (go) begin
      val_nxt = value;
      rem_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      val_nxt = {val_r[62:0], 1'b0};
      if (shifted >= {2'b00, modulus}) begin
        rem_nxt = (mau_pkg::MOD_W+1)'(shifted - {2'b00, modulus});
      end else begin
        rem_nxt = (mau_pkg::MOD_W+1)'(shifted);
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    val_r <= val_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r[mau_pkg::MOD_W-1:0];

endmodule

// ===== verif/tb_modular_arithmetic_unit.sv =====
// self-checking testbench for the modular arithmetic unit
`timescale 1ns / 100ps

module tb_modular_arithmetic_unit;

  localparam int unsigned CYCLE_LIMIT = 40_000_000;
  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    logic [mau_pkg::MOD_W-1:0] result;
    logic                      is_equal;
  } residue_out_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [3:0]              in_func = '0;
  logic signed [63:0]      in_operand_a = '0;
  logic signed [63:0]      in_operand_b = '0;
  logic [62:0]             in_exponent = '0;
  logic                    cfg_we = 1'b0;
  logic [mau_pkg::MOD_W-1:0] cfg_modulus = '0;
  logic                    out_valid;
  logic [mau_pkg::MOD_W-1:0] out_result;
  logic                    out_is_equal;

  // predictor copy of the modulus register
  logic [mau_pkg::MOD_W-1:0] model_modulus = mau_pkg::MODULUS_RESET;
  residue_out_t            pending_results[$];
  logic [3:0]              pending_funcs[$];
  int unsigned             mismatches = 0;
  int unsigned             requests_sent = 0;
  int unsigned             results_seen = 0;
  int unsigned             cycle_count = 0;
  int unsigned             sender_idle_pct = 0;

  modular_arithmetic_unit uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_func      (in_func),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .in_exponent  (in_exponent),
    .cfg_we       (cfg_we),
    .cfg_modulus  (cfg_modulus),
    .out_valid    (out_valid),
    .out_result   (out_result),
    .out_is_equal (out_is_equal)
  );

  // clock
  always #4 clk = ~clk;

  // residue of a signed 64-bit value
  function automatic longint unsigned residue_of(logic [63:0] v, longint unsigned m);
    longint unsigned mag;
    longint unsigned r;
    if (!v[63]) return v % m;
    mag = (~v) + 64'd1;
    r = mag % m;
    return (r != 0) ? m - r : 0;
  endfunction

  // square-and-multiply over the low 63 exponent bits
  function automatic longint unsigned power_mod(longint unsigned base, logic [62:0] e,
                                                longint unsigned m);
    longint unsigned acc;
    longint unsigned sq;
    acc = 1 % m;
    sq = base;
    for (int i = 0; i < 63; i++) begin
      if (e[i]) acc = (acc * sq) % m;
      sq = (sq * sq) % m;
    end
    return acc;
  endfunction

  function automatic longint unsigned fermat_inverse(longint unsigned a, longint unsigned m);
    if (a == 0) return 0;
    return power_mod(a, 63'(m - 2), m);
  endfunction

  // expected result of one request under the current modulus
  function automatic residue_out_t modular_result(logic [3:0] f, logic [63:0] opa,
                                                  logic [63:0] opb, logic [62:0] e);
    residue_out_t    r;
    longint unsigned m;
    longint unsigned a;
    longint unsigned b;
    longint unsigned s;
    longint unsigned v;
    m = model_modulus;
    r = '0;
    if (m < 2) begin
      r.is_equal = (f == mau_pkg::FN_EQU);
      return r;
    end
    a = residue_of(opa, m);
    b = residue_of(opb, m);
    v = 0;
    case (f)
      mau_pkg::FN_RED: v = a;
      mau_pkg::FN_ADD: begin
        s = a + b;
        v = (s >= m) ? s - m : s;
      end
      mau_pkg::FN_SUB: begin
        s = a + (m - b);
        v = (s >= m) ? s - m : s;
      end
      mau_pkg::FN_MUL: v = (a * b) % m;
      mau_pkg::FN_DIV: v = (a * fermat_inverse(b, m)) % m;
      mau_pkg::FN_POW: v = power_mod(a, e, m);
      mau_pkg::FN_INV: v = fermat_inverse(a, m);
      mau_pkg::FN_NEG: v = (a != 0) ? m - a : 0;
      mau_pkg::FN_EQU: r.is_equal = (a == b);
      default: v = 0;
    endcase
    r.result = v[mau_pkg::MOD_W-1:0];
    return r;
  endfunction

  // result checker: every strobe is matched against the oldest expectation
  always @(posedge clk) begin
    residue_out_t want;
    logic [3:0]   f;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result %0d/%0b with no request pending", out_result, out_is_equal);
      end else begin
        want = pending_results.pop_front();
        f = pending_funcs.pop_front();
        if (out_result !== want.result || out_is_equal !== want.is_equal) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("mismatch func %0d: result exp %0d got %0d, is_equal exp %0b got %0b",
                     f, want.result, out_result, want.is_equal, out_is_equal);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // send one request; start is left high for a following request unless the sender idles
  task automatic send_request(logic [3:0] f, logic [63:0] opa, logic [63:0] opb,
                              logic [62:0] e);
    start <= 1'b1;
    in_func <= f;
    in_operand_a <= opa;
    in_operand_b <= opb;
    in_exponent <= e;
    do @(posedge clk); while (busy);
    pending_results.push_back(modular_result(f, opa, opb, e));
    pending_funcs.push_back(f);
    requests_sent++;
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // modulus write, only with nothing in flight
  task automatic write_modulus(logic [mau_pkg::MOD_W-1:0] m);
    drain_results();
    cfg_we <= 1'b1;
    cfg_modulus <= m;
    model_modulus = m;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // operand mix: full range, small signed, and near multiples of the modulus
  function automatic logic [63:0] pick_operand();
    longint unsigned m;
    m = (model_modulus < 2) ? 2 : model_modulus;
    case ($urandom_range(3))
      0, 1: return {$urandom, $urandom};
      2: return 64'(longint'($urandom_range(64)) - 32);
      default: return 64'(longint'($urandom_range(1 << 20)) * longint'(m)
                          * ($urandom_range(1) ? 1 : -1) + longint'($urandom_range(2)) - 1);
    endcase
  endfunction

  function automatic logic [3:0] pick_func();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 84) return 4'(p / 14);
    if (p < 86) return mau_pkg::FN_NEG;
    if (p < 90) return mau_pkg::FN_DIV;
    if (p < 94) return mau_pkg::FN_POW;
    if (p < 97) return mau_pkg::FN_INV;
    return 4'($urandom_range(15, 9));
  endfunction

  // directed corner cases under the current modulus
  task automatic test_corners();
    logic [63:0] min_v;
    logic [63:0] max_v;
    min_v = 64'h8000_0000_0000_0000;
    max_v = 64'h7fff_ffff_ffff_ffff;
    send_request(mau_pkg::FN_RED, min_v, 0, 0);
    send_request(mau_pkg::FN_RED, max_v, 0, 0);
    send_request(mau_pkg::FN_ADD, max_v, max_v, 0);
    send_request(mau_pkg::FN_SUB, min_v, max_v, 0);
    send_request(mau_pkg::FN_MUL, -64'sd1, -64'sd1, 0);
    send_request(mau_pkg::FN_MUL, max_v, min_v, 0);
    send_request(mau_pkg::FN_DIV, 64'd7, 64'd0, 0);
    send_request(mau_pkg::FN_DIV, min_v, 64'd3, 0);
    send_request(mau_pkg::FN_POW, 64'd0, 0, 63'd0);
    send_request(mau_pkg::FN_POW, 64'd0, 0, 63'd5);
    send_request(mau_pkg::FN_POW, -64'sd2, 0, {63{1'b1}});
    send_request(mau_pkg::FN_INV, 64'd0, 0, 0);
    send_request(mau_pkg::FN_INV, -64'sd1, 0, 0);
    send_request(mau_pkg::FN_NEG, 64'd0, 0, 0);
    send_request(mau_pkg::FN_NEG, min_v, 0, 0);
    send_request(mau_pkg::FN_EQU, -64'sd1, 64'(longint'(model_modulus) - 1), 0);
    send_request(mau_pkg::FN_EQU, 64'd1, 64'd2, 0);
    send_request(4'd9, max_v, max_v, 0);
    send_request(4'd15, min_v, min_v, {63{1'b1}});
  endtask

  task automatic test_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      logic [63:0] opa;
      logic [63:0] opb;
      logic [3:0]  f;
      opa = pick_operand();
      f = pick_func();
      // equal requests often compare congruent values
      opb = (f == mau_pkg::FN_EQU && $urandom_range(1)) ?
            64'(opa + 64'(longint'(model_modulus) * longint'($urandom_range(8)))) :
            pick_operand();
      send_request(f, opa, opb, {$urandom, $urandom});
    end
  endtask

  task automatic test_degenerate_modulus();
    write_modulus('0);
    test_corners();
    write_modulus(30'd1);
    test_corners();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_idle_pct = 16;
    test_corners();
    test_random(180);
    write_modulus(30'd1000000007);
    test_random(180);
    test_degenerate_modulus();

    sender_idle_pct = 61;
    write_modulus(30'd2);
    test_corners();
    test_random(120);
    write_modulus({mau_pkg::MOD_W{1'b1}});
    test_corners();
    test_random(180);

    sender_idle_pct = 0;
    write_modulus(30'd65537);
    test_random(180);
    write_modulus(mau_pkg::MODULUS_RESET);
    test_random(180);

    drain_results();
    repeat (20) @(posedge clk);
    $display("%0d requests over seven modulus settings, %0d results checked, %0d mismatches",
             requests_sent, results_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
